// ===== rtl/rpfs_pkg.sv =====
`default_nettype none

package rpfs_pkg;

    // Number format of the measured frequency.
    localparam int FREQ_W      = 24;
    localparam int FRAC_BITS   = 8;
    localparam int TARGET_W    = 16;

    // Search range and defaults.
    localparam int ASYNC_W     = 7;
    localparam int START_ASYNC = 127;
    localparam int LOWEST_A    = 2;
    localparam int TRIES       = 4;
    localparam int DEFAULT_A   = 127;
    localparam int DEFAULT_S   = 255;
    localparam int EXACT_HZ    = 32768;
    localparam logic [TARGET_W-1:0] NO_DIFF = '1;

    // Rounding constant: half of one least significant integer step.
    localparam int HALF = (FRAC_BITS == 0) ? 0 : (1 << (FRAC_BITS - 1));

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CMP,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/rtc_prescaler_factor_search.sv =====
`default_nettype none

// Channel   Group        Payload (lowest bit first)
// -------   ----------   -------------------------------------------------
// in        s_axis_*     measured_freq[23:0]
// out       m_axis_*     async_div[6:0], sync_div[22:7], zero pad [23]
//
// An input of exactly 32768.0 Hz skips the search and loads the standard pair as its result.
// Otherwise, for each A from 127 down to 2, the bit-serial divider runs first, then four
// candidate S values are tried on the shared multiplier and comparator; a zero difference
// stops the search early.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// Requests are taken only while idle; a stalled sink keeps a finished search waiting.
module rtc_prescaler_factor_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // measured_freq[23:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // async_div[6:0], sync_div[22:7], pad[23]
);
    import rpfs_pkg::*;

    localparam int CNT_W  = $clog2(TARGET_W);
    localparam int TRY_W  = $clog2(TRIES);
    localparam int PROD_W = ASYNC_W + TARGET_W;
    localparam int WIDE_W = FREQ_W + TARGET_W;
    localparam logic [WIDE_W-1:0] EXACT_FREQ = WIDE_W'(EXACT_HZ) << FRAC_BITS;

    t_state                r_state, n_state;
    logic [TARGET_W-1:0]   r_target;
    logic [TARGET_W-1:0]   r_quo;
    logic [ASYNC_W-1:0]    r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [ASYNC_W-1:0]    r_a;
    logic [TARGET_W-1:0]   r_s;
    logic [TRY_W-1:0]      r_k;
    logic [TARGET_W-1:0]   r_diff;
    logic [TARGET_W-1:0]   r_best_diff;
    logic [ASYNC_W:0]      r_best_a;
    logic [TARGET_W-1:0]   r_best_s;
    logic                  r_out_valid;
    logic [23:0]           r_out_data;

    logic                  w_accept;
    logic                  w_exact;
    logic [FREQ_W:0]       w_round;
    logic [TARGET_W-1:0]   w_new_target;
    logic [ASYNC_W:0]      w_trial;
    logic                  w_fits;
    logic [TARGET_W-1:0]   w_next_quo;
    logic [ASYNC_W-1:0]    w_next_rem;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_better;
    logic                  w_last_try;
    logic                  w_last_a;
    logic                  w_load_out;

    // Request decode: exact standard frequency and rounding to whole Hz.
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_exact      = (WIDE_W'(s_axis_tdata) == EXACT_FREQ);
    assign w_round      = {1'b0, s_axis_tdata} + (FREQ_W + 1)'(HALF);
    assign w_new_target = TARGET_W'(w_round >> FRAC_BITS);

    // One restoring division step: remainder shifts in the next dividend bit from the top of the quotient register.
    assign w_trial    = {r_rem, r_quo[TARGET_W-1]};
    assign w_fits     = (w_trial >= {1'b0, r_a});
    assign w_next_quo = {r_quo[TARGET_W-2:0], w_fits};
    assign w_next_rem = w_fits ? ASYNC_W'(w_trial - {1'b0, r_a}) : ASYNC_W'(w_trial);

    // Shared multiplier and comparator for the candidate check.
    assign w_prod     = r_a * r_s;
    assign w_better   = (r_diff < r_best_diff);
    assign w_last_try = (r_k == TRY_W'(TRIES - 1));
    assign w_last_a   = (r_a == ASYNC_W'(LOWEST_A));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_exact ? ST_FINISH : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(TARGET_W - 1)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (w_better && (r_diff == '0)) begin
                    n_state = ST_FINISH;
                end else if (w_last_try) begin
                    n_state = w_last_a ? ST_FINISH : ST_DIV;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and the output register load.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_load_out    = (r_state == ST_FINISH) && (!r_out_valid || m_axis_tready);
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_data;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_target    <= w_new_target;
                    r_quo       <= w_new_target;
                    r_rem       <= '0;
                    r_cnt       <= '0;
                    r_a         <= ASYNC_W'(START_ASYNC);
                    r_best_diff <= NO_DIFF;
                    // The exact case stores A and S one above the standard pair,
                    // so that the common minus one yields it unchanged.
                    if (w_exact) begin
                        r_best_a <= (ASYNC_W + 1)'(DEFAULT_A + 1);
                        r_best_s <= TARGET_W'(DEFAULT_S + 1);
                    end else begin
                        r_best_a <= (ASYNC_W + 1)'(DEFAULT_A);
                        r_best_s <= TARGET_W'(DEFAULT_S);
                    end
                end
            end
            ST_DIV: begin
                r_quo <= w_next_quo;
                r_rem <= w_next_rem;
                r_cnt <= r_cnt + 1'b1;
                // The first candidate S is the quotient plus two.
                if (r_cnt == CNT_W'(TARGET_W - 1)) begin
                    r_s <= w_next_quo + TARGET_W'(2);
                    r_k <= '0;
                end
            end
            ST_MUL: begin
                r_diff <= w_prod[TARGET_W-1:0] - r_target;
            end
            ST_CMP: begin
                if (w_better) begin
                    r_best_diff <= r_diff;
                    r_best_a    <= {1'b0, r_a};
                    r_best_s    <= r_s;
                end
                r_s <= r_s - 1'b1;
                r_k <= r_k + 1'b1;
                // Move on to the next smaller A and restart the divider.
                if (w_last_try) begin
                    r_a   <= r_a - 1'b1;
                    r_quo <= r_target;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            ST_FINISH: begin
                if (w_load_out) begin
                    r_out_data <= {1'b0, TARGET_W'(r_best_s - 1'b1),
                                   ASYNC_W'(r_best_a - 1'b1)};
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // The divider leaves a correct quotient and remainder for the current A.
    a_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_W'(TARGET_W - 1)) |=>
        ((32'(r_quo) * 32'(r_a) + 32'(r_rem) == 32'(r_target)) && (r_rem < r_a)))
        else $error("divider result does not match target and A");

    // The best difference never grows during a search.
    a_best_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |=> (r_best_diff <= $past(r_best_diff)))
        else $error("best difference grew");

    // A stays inside its search range while the search runs.
    a_a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_MUL || r_state == ST_CMP) |->
        (r_a >= ASYNC_W'(LOWEST_A) && r_a <= ASYNC_W'(START_ASYNC)))
        else $error("A out of search range");

    // A zero difference ends the search at once.
    a_zero_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && w_better && r_diff == '0) |=> (r_state == ST_FINISH))
        else $error("search went on after an exact match");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;

    import rpfs_pkg::*;

    // Expected pair of prescaler factors, laid out as on the result bus.
    typedef struct packed {
        logic [TARGET_W-1:0] sync_div;
        logic [ASYNC_W-1:0]  async_div;
    } t_divs;

    localparam int REPORT_MAX  = 10;
    localparam int SECOND_HOLD = 120;
    localparam int SETTLE_CYC  = 3200;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [FREQ_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;

    // Frequencies still to be requested and factor pairs still to be returned.
    logic [FREQ_W-1:0] freq_backlog[$];
    t_divs             pending_divs[$];

    int mismatch_cnt = 0;
    int total_items  = 0;
    int first_hold   = 0;

    // Driver bookkeeping, touched only by the driver process.
    int sent_cnt   = 0;
    int seen_cnt   = 0;
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall pattern.
    int run_left   = 0;
    int stall_left = 0;

    rtc_prescaler_factor_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // measured_freq[23:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // async_div[6:0], sync_div[22:7], pad[23]
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Search for the factor pair whose product lies closest at or above the rounded frequency.
    function automatic t_divs pick_prescalers(input logic [FREQ_W-1:0] freq);
        t_divs               res;
        logic [31:0]         rounded;
        logic [31:0]         a;
        logic [31:0]         best_a;
        logic [TARGET_W-1:0] target;
        logic [TARGET_W-1:0] best_diff;
        logic [TARGET_W-1:0] best_s;
        logic [TARGET_W-1:0] s;
        logic [TARGET_W-1:0] diff;
        bit                  hit;
        if (freq == FREQ_W'(EXACT_HZ << FRAC_BITS)) begin
            // The standard crystal gives the standard pair with no offset applied.
            res.async_div = ASYNC_W'(DEFAULT_A);
            res.sync_div  = TARGET_W'(DEFAULT_S);
            return res;
        end
        rounded   = 32'(freq) + 32'(HALF);
        target    = TARGET_W'(rounded >> FRAC_BITS);
        best_diff = NO_DIFF;
        best_a    = 32'(DEFAULT_A);
        best_s    = TARGET_W'(DEFAULT_S);
        hit       = 1'b0;
        for (a = 32'(START_ASYNC); a >= 32'(LOWEST_A) && !hit; a = a - 1) begin
            s = TARGET_W'(32'(target) / a + 32'd2);
            for (int k = 0; k < TRIES && !hit; k++) begin
                diff = TARGET_W'(a * 32'(s) - 32'(target));
                if (diff < best_diff) begin
                    best_diff = diff;
                    best_a    = a;
                    best_s    = s;
                    if (diff == '0) begin
                        hit = 1'b1;
                    end
                end
                s = s - 1'b1;
            end
        end
        res.async_div = ASYNC_W'(best_a - 32'd1);
        res.sync_div  = best_s - 1'b1;
        return res;
    endfunction

    // Random frequency, weighted towards values near the nominal crystal.
    function automatic logic [FREQ_W-1:0] random_freq();
        logic [31:0] hz;
        logic [31:0] mult;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return FREQ_W'($urandom());
            4, 5, 6: begin
                hz = $urandom_range(30000, 36000);
                return {hz[15:0], 8'($urandom())};
            end
            7: return FREQ_W'($urandom_range(0, 4096 * 256));
            8: return FREQ_W'((EXACT_HZ << FRAC_BITS) + $urandom_range(0, 8) - 4);
            default: begin
                // A whole product of some A and S, so that the search may stop early.
                mult = $urandom_range(LOWEST_A, START_ASYNC) * $urandom_range(0, 32768);
                return {mult[15:0], 8'($urandom_range(0, 255) < 128 ? 0 : $urandom())};
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        if (mismatch_cnt < REPORT_MAX) begin
            $display("Mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
        end
        mismatch_cnt++;
    endtask

    // Driver: sends requests in bursts, with gaps and, at two points, a pause until all results are back.
    always @(posedge i_clk) begin
        logic              next_valid;
        logic [FREQ_W-1:0] next_data;
        bit                hold;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            sent_cnt       = 0;
            seen_cnt       = 0;
            burst_left     = 1;
            gap_left       = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent_cnt = sent_cnt + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_cnt = seen_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                hold       = (sent_cnt == first_hold || sent_cnt == SECOND_HOLD) &&
                             (seen_cnt != sent_cnt);
                next_valid = 1'b0;
                next_data  = '0;
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (!hold && freq_backlog.size() != 0) begin
                    next_data  = freq_backlog.pop_front();
                    next_valid = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                s_axis_tvalid <= next_valid;
                if (next_valid) begin
                    s_axis_tdata <= next_data;
                end
            end
        end
    end

    // Receiver: ready in runs of random length, broken by stalls short and long.
    always @(posedge i_clk) begin
        int mode;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            run_left       = 0;
            stall_left     = 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (run_left > 0) begin
            run_left = run_left - 1;
            m_axis_tready <= 1'b1;
        end else begin
            mode       = $urandom_range(0, 5);
            run_left   = $urandom_range(0, 30);
            stall_left = (mode == 0) ? 0 : $urandom_range(1, (mode == 5) ? 60 : 12);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Monitor: checks each result against the oldest prediction, then records new requests.
    always @(posedge i_clk) begin
        t_divs exp_divs;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_divs.size() == 0) begin
                    if (mismatch_cnt < REPORT_MAX) begin
                        $display("Result with no request outstanding: 0x%06h", m_axis_tdata);
                    end
                    mismatch_cnt++;
                end else begin
                    exp_divs = pending_divs.pop_front();
                    if (m_axis_tdata[6:0] !== exp_divs.async_div) begin
                        report_mismatch("async_div", exp_divs.async_div, m_axis_tdata[6:0]);
                    end
                    if (m_axis_tdata[22:7] !== exp_divs.sync_div) begin
                        report_mismatch("sync_div", exp_divs.sync_div, m_axis_tdata[22:7]);
                    end
                    if (m_axis_tdata[23] !== 1'b0) begin
                        report_mismatch("pad bit", 0, m_axis_tdata[23]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_divs.push_back(pick_prescalers(s_axis_tdata));
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        // Field extremes, the exact crystal and its neighbours, rounding edges,
        // tiny frequencies where S wraps, a zero target and a prime with no exact fit.
        freq_backlog.push_back(24'h000000);
        freq_backlog.push_back(24'hFFFFFF);
        freq_backlog.push_back(FREQ_W'(EXACT_HZ << FRAC_BITS));
        freq_backlog.push_back(FREQ_W'((EXACT_HZ << FRAC_BITS) + 1));
        freq_backlog.push_back(FREQ_W'((EXACT_HZ << FRAC_BITS) - 1));
        freq_backlog.push_back(FREQ_W'((EXACT_HZ << FRAC_BITS) - 128));
        freq_backlog.push_back(FREQ_W'((EXACT_HZ << FRAC_BITS) + 127));
        freq_backlog.push_back(24'h00007F);
        freq_backlog.push_back(24'h000080);
        freq_backlog.push_back(24'h000100);
        freq_backlog.push_back(24'h000200);
        freq_backlog.push_back(24'h000380);
        freq_backlog.push_back(24'hFFFF80);
        freq_backlog.push_back(24'hFFFF7F);
        freq_backlog.push_back(FREQ_W'(65521 << FRAC_BITS));
        freq_backlog.push_back(FREQ_W'((127 * 200) << FRAC_BITS));
        freq_backlog.push_back(FREQ_W'(65534 << FRAC_BITS));
        freq_backlog.push_back(24'h555555);
        freq_backlog.push_back(24'hAAAAAA);
        first_hold = freq_backlog.size();
        repeat (200) begin
            freq_backlog.push_back(random_freq());
        end
        total_items = freq_backlog.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < total_items || pending_divs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYC) @(negedge i_clk);

        if (mismatch_cnt == 0 && pending_divs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a stuck handshake.
    initial begin
        #6000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
